// File: rtl/core/wstd_pkg.sv
// Shared types and constants of the work-stealing task dispatcher.
`default_nettype none

package wstd_pkg;

    localparam int NUM_WORKERS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_WIDTH_DEF  = 32;

    localparam int TAG_W          = 32;
    localparam int WORKER_ID_W    = 3;
    localparam int TARGET_W       = 3;
    localparam int OUTSTANDING_W  = 16;
    localparam int WORKER_COUNT_W = 4;

    localparam logic [WORKER_COUNT_W-1:0] WORKER_COUNT_RST = 4'd8;

    typedef enum logic [1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_BATCH  = 2'd1,
        FUNC_FETCH  = 2'd2,
        FUNC_DONE   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                  func;
        logic [TAG_W-1:0]       task_tag;
        logic                   task_null;
        logic                   batch_start;
        logic [WORKER_ID_W-1:0] worker_id;
    } t_in_item;

    typedef struct packed {
        logic                     accepted;
        logic                     queue_full;
        logic [TARGET_W-1:0]      target_worker;
        logic                     got_task;
        logic                     stolen;
        logic [TAG_W-1:0]         task_out;
        logic [OUTSTANDING_W-1:0] outstanding;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/wstd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wstd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/work_stealing_task_dispatcher_core.sv
// Top level of the work-stealing task dispatcher: sequencer, queue pointers and task store.
`default_nettype none

// Usage
//   Command channel: drive i_item and raise start; the command transfers at the
//   rising edge where start is high and busy is low. busy stays high until the
//   result has been produced. Every command gives exactly one result, shown on
//   o_result for one cycle with o_valid high; the receiver cannot stall it.
//   Config: i_cfg_we with i_cfg_wdata writes worker_count; write only while idle.
//   Completions and null single submits give their result without leaving idle.
//   Submits, batch submits and fetches first reduce the pointer or worker id
//   modulo the active worker count in the shared compare/subtract unit, which
//   subtracts the count while the value is out of range, as it can be after the
//   count has been lowered. A fetch that finds its own queue empty scans up to
//   n-1 victim queues, n being the active worker count. The next command can be
//   taken in the cycle o_valid is high. The steal scan checks one queue's fill
//   count per cycle; task data comes from a RAM with registered read.
//   Reset: all queues empty, pointers and outstanding count zero, worker_count 8.
//   The task store is not cleared; only entries counted as filled are read.
module work_stealing_task_dispatcher_core #(
    parameter int NUM_WORKERS = wstd_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = wstd_pkg::TASK_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire wstd_pkg::t_in_item                  i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [wstd_pkg::WORKER_COUNT_W-1:0] i_cfg_wdata,
    output logic                                     o_valid,
    output wstd_pkg::t_out_item                      o_result
);

    localparam int WID_W  = $clog2(NUM_WORKERS);
    localparam int VAL_W  = (WID_W > wstd_pkg::WORKER_ID_W) ? WID_W : wstd_pkg::WORKER_ID_W;
    localparam int N_W    = VAL_W + 1;
    localparam int QD_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OUT_W  = wstd_pkg::OUTSTANDING_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_EXEC,
        S_SCAN,
        S_READ
    } t_state;

    // Control state
    t_state                              r_state, n_state;
    logic [WID_W-1:0]                    r_rr, n_rr;
    logic [WID_W-1:0]                    r_bpos, n_bpos;
    logic [OUT_W-1:0]                    r_pending, n_pending;
    logic [wstd_pkg::WORKER_COUNT_W-1:0] r_wc, n_wc;
    logic                                r_valid, n_valid;
    logic [QD_W-1:0]                     r_head [NUM_WORKERS];
    logic [FILL_W-1:0]                   r_fill [NUM_WORKERS];

    // Working payload
    wstd_pkg::t_in_item                  r_item, n_item;
    wstd_pkg::t_out_item                 r_result, n_result;
    logic [N_W-1:0]                      r_val, n_val;
    logic [WID_W-1:0]                    r_q, n_q;
    logic [WID_W-1:0]                    r_home, n_home;
    logic                                r_stolen, n_stolen;

    // Datapath
    logic [N_W-1:0]        n_eff;
    logic [N_W-1:0]        q_wide;
    logic [N_W-1:0]        q_inc;
    logic [N_W-1:0]        q_next;
    logic [QD_W-1:0]       head_cur;
    logic [FILL_W-1:0]     fill_cur;
    logic [QD_W-1:0]       head_inc;
    logic [FILL_W-1:0]     fill_off;
    logic [FILL_W:0]       slot_sum;
    logic [QD_W-1:0]       slot;
    logic [ADDR_W-1:0]     addr_base;
    logic [OUT_W-1:0]      pend_inc;
    logic [OUT_W-1:0]      pend_dec;
    logic                  q_upd;
    logic [QD_W-1:0]       q_head_new;
    logic [FILL_W-1:0]     q_fill_new;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [TASK_WIDTH-1:0] ram_wdata;
    logic [TASK_WIDTH-1:0] ram_rdata;
    logic [63:0]           tag_wide;
    logic [63:0]           rd_wide;

    // Clamp the configured count to 1..NUM_WORKERS
    always_comb begin
        if (r_wc == '0) begin
            n_eff = N_W'(1);
        end else if (int'(r_wc) > NUM_WORKERS) begin
            n_eff = N_W'(NUM_WORKERS);
        end else begin
            n_eff = N_W'(r_wc);
        end
    end

    assign q_wide   = N_W'(r_q);
    assign q_inc    = q_wide + N_W'(1);
    assign q_next   = (q_inc == n_eff) ? '0 : q_inc;
    assign head_cur = r_head[r_q];
    assign fill_cur = r_fill[r_q];
    assign head_inc = (head_cur == QD_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + QD_W'(1);

    // Back slot: head + fill for a push, head + fill - 1 for a steal
    assign fill_off  = (r_state == S_SCAN) ? fill_cur - FILL_W'(1) : fill_cur;
    assign slot_sum  = (FILL_W + 1)'(head_cur) + (FILL_W + 1)'(fill_off);
    assign slot      = (slot_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
                     ? QD_W'(slot_sum - (FILL_W + 1)'(QUEUE_DEPTH))
                     : QD_W'(slot_sum);
    assign addr_base = ADDR_W'(r_q) * ADDR_W'(QUEUE_DEPTH);

    assign pend_inc = (r_pending == '1) ? r_pending : r_pending + OUT_W'(1);
    assign pend_dec = (r_pending == '0) ? r_pending : r_pending - OUT_W'(1);

    assign tag_wide  = 64'(r_item.task_tag);
    assign ram_wdata = tag_wide[TASK_WIDTH-1:0];
    assign rd_wide   = 64'(ram_rdata);

    always_comb begin
        n_state    = r_state;
        n_rr       = r_rr;
        n_bpos     = r_bpos;
        n_pending  = r_pending;
        n_wc       = r_wc;
        n_valid    = 1'b0;
        n_item     = r_item;
        n_result   = r_result;
        n_val      = r_val;
        n_q        = r_q;
        n_home     = r_home;
        n_stolen   = r_stolen;
        q_upd      = 1'b0;
        q_head_new = head_cur;
        q_fill_new = fill_cur;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = addr_base + ADDR_W'(slot);

        if (i_cfg_we) begin
            n_wc = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    unique case (i_item.func)
                        wstd_pkg::FUNC_SUBMIT: begin
                            if (i_item.task_null) begin
                                // drop: nothing moves
                                n_result             = '0;
                                n_result.outstanding = r_pending;
                                n_valid              = 1'b1;
                            end else begin
                                n_val   = N_W'(r_rr);
                                n_state = S_MOD;
                            end
                        end
                        wstd_pkg::FUNC_BATCH: begin
                            n_val   = i_item.batch_start ? '0 : N_W'(r_bpos);
                            n_state = S_MOD;
                        end
                        wstd_pkg::FUNC_FETCH: begin
                            n_val   = N_W'(i_item.worker_id);
                            n_state = S_MOD;
                        end
                        wstd_pkg::FUNC_DONE: begin
                            n_pending            = pend_dec;
                            n_result             = '0;
                            n_result.outstanding = pend_dec;
                            n_valid              = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            S_MOD: begin
                // shared compare/subtract: reduce modulo the active count
                if (r_val >= n_eff) begin
                    n_val = r_val - n_eff;
                end else begin
                    n_q     = r_val[WID_W-1:0];
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_item.func) inside
                    wstd_pkg::FUNC_SUBMIT, wstd_pkg::FUNC_BATCH: begin
                        if (r_item.func == wstd_pkg::FUNC_SUBMIT) begin
                            n_rr = q_next[WID_W-1:0];
                        end else begin
                            n_bpos = q_next[WID_W-1:0];
                        end
                        n_result             = '0;
                        n_result.outstanding = r_pending;
                        if (!r_item.task_null) begin
                            n_result.target_worker = q_wide[wstd_pkg::TARGET_W-1:0];
                            if (fill_cur == FILL_W'(QUEUE_DEPTH)) begin
                                n_result.queue_full = 1'b1;
                            end else begin
                                ram_we               = 1'b1;
                                q_upd                = 1'b1;
                                q_fill_new           = fill_cur + FILL_W'(1);
                                n_pending            = pend_inc;
                                n_result.accepted    = 1'b1;
                                n_result.outstanding = pend_inc;
                            end
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    wstd_pkg::FUNC_FETCH: begin
                        if (fill_cur != '0) begin
                            // pop the front of the own queue
                            ram_re     = 1'b1;
                            ram_addr   = addr_base + ADDR_W'(head_cur);
                            q_upd      = 1'b1;
                            q_head_new = head_inc;
                            q_fill_new = fill_cur - FILL_W'(1);
                            n_stolen   = 1'b0;
                            n_state    = S_READ;
                        end else begin
                            n_home = r_q;
                            if (q_next == q_wide) begin
                                n_result             = '0;
                                n_result.outstanding = r_pending;
                                n_valid              = 1'b1;
                                n_state              = S_IDLE;
                            end else begin
                                n_q     = q_next[WID_W-1:0];
                                n_state = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                if (fill_cur != '0) begin
                    // steal from the back of the victim
                    ram_re     = 1'b1;
                    q_upd      = 1'b1;
                    q_fill_new = fill_cur - FILL_W'(1);
                    n_stolen   = 1'b1;
                    n_state    = S_READ;
                end else if (q_next == N_W'(r_home)) begin
                    n_result             = '0;
                    n_result.outstanding = r_pending;
                    n_valid              = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    n_q = q_next[WID_W-1:0];
                end
            end

            S_READ: begin
                n_result               = '0;
                n_result.got_task      = 1'b1;
                n_result.stolen        = r_stolen;
                n_result.target_worker = q_wide[wstd_pkg::TARGET_W-1:0];
                n_result.task_out      = rd_wide[wstd_pkg::TAG_W-1:0];
                n_result.outstanding   = r_pending;
                n_valid                = 1'b1;
                n_state                = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rr      <= '0;
            r_bpos    <= '0;
            r_pending <= '0;
            r_wc      <= wstd_pkg::WORKER_COUNT_RST;
            r_valid   <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rr      <= n_rr;
            r_bpos    <= n_bpos;
            r_pending <= n_pending;
            r_wc      <= n_wc;
            r_valid   <= n_valid;
            if (q_upd) begin
                r_head[r_q] <= q_head_new;
                r_fill[r_q] <= q_fill_new;
            end
        end
        r_item   <= n_item;
        r_result <= n_result;
        r_val    <= n_val;
        r_q      <= n_q;
        r_home   <= n_home;
        r_stolen <= n_stolen;
    end

    wstd_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (DEPTH)
    ) u_task_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
